// ===== design/b2dlw_pkg.sv =====
// ----------------------------------------------------------------------------
// b2dlw_pkg: shared types, constants and microprogram
// Item layouts, state and opcode types, Q16.16 helpers and the fixed
// microprogram that the cell engine steps through for one compute item.
// ----------------------------------------------------------------------------
package b2dlw_pkg;

    localparam int GRID_X = 64;
    localparam int GRID_Y = 64;
    localparam int ROW_W  = $clog2(GRID_X);
    localparam int COL_W  = $clog2(GRID_Y);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = GRID_X * GRID_Y;

    localparam int NREG      = 8;
    localparam int CFG_IDX_W = 3;
    localparam int COEF_W    = 31;

    localparam int PC_W     = 7;
    localparam int RF_DEPTH = 32;
    localparam int RF_IDX_W = 5;
    localparam int OPND_W   = 6;

    // Intermediate values saturate to +-(2^62-1).
    localparam logic signed [64:0] LIM65  = 65'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] NLIM65 = -65'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] LIM64  = 64'sh3FFF_FFFF_FFFF_FFFF;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_AX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NU = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_G  = 3'd7;

    // Register file slots. The five cells are loaded P, E, W, N, S.
    localparam logic [RF_IDX_W-1:0] R_UP   = 5'd0;
    localparam logic [RF_IDX_W-1:0] R_VP   = 5'd5;
    localparam logic [RF_IDX_W-1:0] R_AE   = 5'd10;
    localparam logic [RF_IDX_W-1:0] R_AW   = 5'd11;
    localparam logic [RF_IDX_W-1:0] R_BN   = 5'd12;
    localparam logic [RF_IDX_W-1:0] R_BS   = 5'd13;
    localparam logic [RF_IDX_W-1:0] R_VISC = 5'd14;
    localparam logic [RF_IDX_W-1:0] R_FE   = 5'd15;
    localparam logic [RF_IDX_W-1:0] R_FP   = 5'd16;
    localparam logic [RF_IDX_W-1:0] R_FW   = 5'd17;
    localparam logic [RF_IDX_W-1:0] R_GN   = 5'd18;
    localparam logic [RF_IDX_W-1:0] R_GP   = 5'd19;
    localparam logic [RF_IDX_W-1:0] R_GS   = 5'd20;
    localparam logic [RF_IDX_W-1:0] R_T    = 5'd21;
    localparam logic [RF_IDX_W-1:0] R_X    = 5'd22;
    localparam logic [RF_IDX_W-1:0] R_Y    = 5'd23;
    localparam logic [RF_IDX_W-1:0] R_Z    = 5'd24;

    // Neighbor offsets inside a set of five loaded cells.
    localparam logic [RF_IDX_W-1:0] NB_P = 5'd0;
    localparam logic [RF_IDX_W-1:0] NB_E = 5'd1;
    localparam logic [RF_IDX_W-1:0] NB_W = 5'd2;
    localparam logic [RF_IDX_W-1:0] NB_N = 5'd3;
    localparam logic [RF_IDX_W-1:0] NB_S = 5'd4;

    localparam int PRE_LEN  = 12;
    localparam int HALF_LEN = 39;
    localparam logic [PC_W-1:0] LAST_PC = 7'(PRE_LEN + 2 * HALF_LEN - 1);

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_NEG,
        OP_NPOS,
        OP_AVG,
        OP_MUL16,
        OP_MUL17,
        OP_CLIPU,
        OP_CLIPV
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_EXEC,
        ST_MULW,
        ST_FIN
    } state_t;

    typedef struct packed {
        op_t                 op;
        logic [RF_IDX_W-1:0] dst;
        logic [OPND_W-1:0]   a;
        logic [OPND_W-1:0]   b;
    } instr_t;

    typedef struct packed {
        logic start;
        logic sh17;
    } mul_req_t;

    typedef struct packed {
        logic                cmd;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic signed [31:0]  u_in;
        logic signed [31:0]  v_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] u_out;
        logic signed [31:0] v_out;
        logic               saturated;
    } out_item_t;

    function automatic logic [OPND_W-1:0] rs(input logic [RF_IDX_W-1:0] idx);
        return {1'b0, idx};
    endfunction

    function automatic logic [OPND_W-1:0] cs(input logic [CFG_IDX_W-1:0] idx);
        return {3'b100, idx};
    endfunction

    function automatic instr_t mk(input op_t op, input logic [RF_IDX_W-1:0] dst,
                                  input logic [OPND_W-1:0] a,
                                  input logic [OPND_W-1:0] b);
        instr_t i;
        i.op  = op;
        i.dst = dst;
        i.a   = a;
        i.b   = b;
        return i;
    endfunction

    function automatic logic signed [63:0] sat62(input logic signed [64:0] s);
        logic signed [63:0] r;
        if (s > LIM65) begin
            r = LIM64;
        end else if (s < NLIM65) begin
            r = -LIM64;
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    // Returns {clipped flag, 32-bit value}.
    function automatic logic [32:0] clip32(input logic signed [63:0] x);
        logic [32:0] r;
        if (x > 64'sh7FFF_FFFF) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (x < -64'sh8000_0000) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

    // The program: a shared preamble (compression term, viscosity, face
    // averages), then one half for u and one for v. Each half builds the
    // fluxes, the Lax-Wendroff convective term, the Laplacian and the clip.
    function automatic instr_t prog(input logic [PC_W-1:0] pc);
        instr_t              i;
        logic [PC_W-1:0]     k;
        logic                vh;
        logic [RF_IDX_W-1:0] bs;
        i  = mk(OP_ADD, R_T, rs(R_T), rs(R_T));
        vh = 1'b0;
        k  = '0;
        if (pc < 7'(PRE_LEN)) begin
            unique case (pc)
                7'd0:    i = mk(OP_SUB,   R_T,    rs(R_UP + NB_E), rs(R_UP + NB_W));
                7'd1:    i = mk(OP_MUL16, R_T,    cs(CFG_AX), rs(R_T));
                7'd2:    i = mk(OP_SUB,   R_X,    rs(R_VP + NB_N), rs(R_VP + NB_S));
                7'd3:    i = mk(OP_MUL16, R_X,    cs(CFG_AY), rs(R_X));
                7'd4:    i = mk(OP_ADD,   R_T,    rs(R_T), rs(R_X));
                7'd5:    i = mk(OP_NPOS,  R_T,    rs(R_T), rs(R_T));
                7'd6:    i = mk(OP_MUL16, R_T,    cs(CFG_G), rs(R_T));
                7'd7:    i = mk(OP_ADD,   R_VISC, cs(CFG_NU), rs(R_T));
                7'd8:    i = mk(OP_AVG,   R_AE,   rs(R_UP), rs(R_UP + NB_E));
                7'd9:    i = mk(OP_AVG,   R_AW,   rs(R_UP + NB_W), rs(R_UP));
                7'd10:   i = mk(OP_AVG,   R_BN,   rs(R_VP), rs(R_VP + NB_N));
                default: i = mk(OP_AVG,   R_BS,   rs(R_VP + NB_S), rs(R_VP));
            endcase
        end else begin
            if (pc < 7'(PRE_LEN + HALF_LEN)) begin
                k = pc - 7'(PRE_LEN);
            end else begin
                vh = 1'b1;
                k  = pc - 7'(PRE_LEN + HALF_LEN);
            end
            bs = vh ? R_VP : R_UP;
            unique case (k)
                7'd0: i = vh ? mk(OP_MUL16, R_FE, rs(R_UP + NB_E), rs(R_VP + NB_E))
                             : mk(OP_MUL17, R_FE, rs(R_UP + NB_E), rs(R_UP + NB_E));
                7'd1: i = vh ? mk(OP_MUL16, R_FP, rs(R_UP), rs(R_VP))
                             : mk(OP_MUL17, R_FP, rs(R_UP), rs(R_UP));
                7'd2: i = vh ? mk(OP_MUL16, R_FW, rs(R_UP + NB_W), rs(R_VP + NB_W))
                             : mk(OP_MUL17, R_FW, rs(R_UP + NB_W), rs(R_UP + NB_W));
                7'd3: i = vh ? mk(OP_MUL17, R_GN, rs(R_VP + NB_N), rs(R_VP + NB_N))
                             : mk(OP_MUL16, R_GN, rs(R_UP + NB_N), rs(R_VP + NB_N));
                7'd4: i = vh ? mk(OP_MUL17, R_GP, rs(R_VP), rs(R_VP))
                             : mk(OP_MUL16, R_GP, rs(R_UP), rs(R_VP));
                7'd5: i = vh ? mk(OP_MUL17, R_GS, rs(R_VP + NB_S), rs(R_VP + NB_S))
                             : mk(OP_MUL16, R_GS, rs(R_UP + NB_S), rs(R_VP + NB_S));
                7'd6:  i = mk(OP_SUB,   R_X, rs(R_FE), rs(R_FW));
                7'd7:  i = mk(OP_MUL16, R_X, cs(CFG_AX), rs(R_X));
                7'd8:  i = mk(OP_NEG,   R_T, rs(R_X), rs(R_X));
                7'd9:  i = mk(OP_SUB,   R_Y, rs(R_FE), rs(R_FP));
                7'd10: i = mk(OP_MUL16, R_Y, rs(R_AE), rs(R_Y));
                7'd11: i = mk(OP_SUB,   R_Z, rs(R_FP), rs(R_FW));
                7'd12: i = mk(OP_MUL16, R_Z, rs(R_AW), rs(R_Z));
                7'd13: i = mk(OP_SUB,   R_Y, rs(R_Y), rs(R_Z));
                7'd14: i = mk(OP_MUL16, R_Y, cs(CFG_LX), rs(R_Y));
                7'd15: i = mk(OP_ADD,   R_T, rs(R_T), rs(R_Y));
                7'd16: i = mk(OP_SUB,   R_X, rs(R_GN), rs(R_GS));
                7'd17: i = mk(OP_MUL16, R_X, cs(CFG_AY), rs(R_X));
                7'd18: i = mk(OP_SUB,   R_T, rs(R_T), rs(R_X));
                7'd19: i = mk(OP_SUB,   R_Y, rs(R_GN), rs(R_GP));
                7'd20: i = mk(OP_MUL16, R_Y, rs(R_BN), rs(R_Y));
                7'd21: i = mk(OP_SUB,   R_Z, rs(R_GP), rs(R_GS));
                7'd22: i = mk(OP_MUL16, R_Z, rs(R_BS), rs(R_Z));
                7'd23: i = mk(OP_SUB,   R_Y, rs(R_Y), rs(R_Z));
                7'd24: i = mk(OP_MUL16, R_Y, cs(CFG_LY), rs(R_Y));
                7'd25: i = mk(OP_ADD,   R_T, rs(R_T), rs(R_Y));
                7'd26: i = mk(OP_SUB,   R_X, rs(bs + NB_E), rs(bs + NB_P));
                7'd27: i = mk(OP_SUB,   R_Y, rs(bs + NB_W), rs(bs + NB_P));
                7'd28: i = mk(OP_ADD,   R_X, rs(R_X), rs(R_Y));
                7'd29: i = mk(OP_MUL16, R_X, cs(CFG_KX), rs(R_X));
                7'd30: i = mk(OP_SUB,   R_Y, rs(bs + NB_N), rs(bs + NB_P));
                7'd31: i = mk(OP_SUB,   R_Z, rs(bs + NB_S), rs(bs + NB_P));
                7'd32: i = mk(OP_ADD,   R_Y, rs(R_Y), rs(R_Z));
                7'd33: i = mk(OP_MUL16, R_Y, cs(CFG_KY), rs(R_Y));
                7'd34: i = mk(OP_ADD,   R_X, rs(R_X), rs(R_Y));
                7'd35: i = mk(OP_MUL16, R_X, rs(R_VISC), rs(R_X));
                7'd36: i = mk(OP_ADD,   R_T, rs(bs + NB_P), rs(R_T));
                7'd37: i = mk(OP_ADD,   R_T, rs(R_T), rs(R_X));
                default: i = vh ? mk(OP_CLIPV, R_T, rs(R_T), rs(R_T))
                                : mk(OP_CLIPU, R_T, rs(R_T), rs(R_T));
            endcase
        end
        return i;
    endfunction

endpackage

// ===== design/b2dlw_if.sv =====
// ----------------------------------------------------------------------------
// b2dlw_if: item channels of the Burgers cell engine
// Valid/ready channels carrying one input item or one result item.
// ----------------------------------------------------------------------------
interface b2dlw_req_if;
    logic                valid;
    logic                ready;
    b2dlw_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface b2dlw_rsp_if;
    logic                 valid;
    logic                 ready;
    b2dlw_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/burgers_2d_lax_wendroff_cell_top.sv =====
// ----------------------------------------------------------------------------
// burgers_2d_lax_wendroff_cell_top: 2D viscous Burgers Lax-Wendroff cell engine
// Holds a periodic 64x64 grid of Q16.16 (u,v) pairs and returns the
// Lax-Wendroff update of one cell per compute item.
// ----------------------------------------------------------------------------
// A write item stores one cell and returns one all-zero result item. A compute
// item reads the cell and its four wrapped neighbors from the two grid
// memories, then runs a fixed 90-step microprogram on one shared saturating
// adder and one shared multiplier. Each step has an operand fetch state and an
// execute state, and each of the 37 multiplications adds a wait state while
// the multiplier builds a 62x62-bit exact product from four 32x32 partial
// products. The block takes one item at a time: req.ready is high only while
// it is idle, but a finished result may still wait in the output register
// while the next item is accepted. The user must write configuration
// registers through cfg_we/cfg_index/cfg_value only while the block is idle;
// the block itself does not enforce this. Reading a cell that was never
// written gives an unspecified result.
// ----------------------------------------------------------------------------
module burgers_2d_lax_wendroff_cell_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    b2dlw_req_if.sink                               req,
    b2dlw_rsp_if.source                             rsp,
    input  logic                                    cfg_we,
    input  logic [b2dlw_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [b2dlw_pkg::COEF_W-1:0]            cfg_value
);
    import b2dlw_pkg::*;

    localparam logic [2:0] RD_LAST = 3'd5;

    // Sequencer state.
    state_t          state_reg;
    state_t          state_next;
    logic [PC_W-1:0] pc_reg;
    logic [2:0]      rd_cnt_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;

    // Configuration registers.
    logic [COEF_W-1:0] cfg_reg [NREG];

    // Grid memories and their registered read data.
    logic [31:0] u_mem [DEPTH];
    logic [31:0] v_mem [DEPTH];
    logic [31:0] rd_u_reg;
    logic [31:0] rd_v_reg;
    logic [ADDR_W-1:0] rd_addr;

    // Working register file and the registered operands of the current step.
    logic signed [63:0] rf [RF_DEPTH];
    logic signed [63:0] opa_reg;
    logic signed [63:0] opb_reg;

    // Result staging and output register.
    logic [31:0] res_u_reg;
    logic [31:0] res_v_reg;
    logic        sat_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    instr_t             instr;
    logic               is_mul;
    logic               accept;
    logic               wr_en;
    logic               load_out;
    mul_req_t           mul_req;
    logic               mul_done;
    logic signed [63:0] mul_res;
    logic signed [63:0] opa_sel;
    logic signed [63:0] opb_sel;
    logic signed [64:0] sum65;
    logic signed [64:0] dif65;
    logic signed [64:0] avg65;
    logic signed [63:0] alu_res;
    logic [32:0]        clip_res;

    assign instr  = prog(pc_reg);
    assign is_mul = (instr.op == OP_MUL16) || (instr.op == OP_MUL17);
    assign accept = req.valid && req.ready;
    assign wr_en  = accept && (req.data.cmd == CMD_WRITE);

    // Neighbor addresses wrap with the index width of the grid.
    always_comb
    begin
        unique case (rd_cnt_reg)
            3'd1:    rd_addr = {ROW_W'(row_reg + 1'b1), col_reg};
            3'd2:    rd_addr = {ROW_W'(row_reg - 1'b1), col_reg};
            3'd3:    rd_addr = {row_reg, COL_W'(col_reg + 1'b1)};
            3'd4:    rd_addr = {row_reg, COL_W'(col_reg - 1'b1)};
            default: rd_addr = {row_reg, col_reg};
        endcase
    end

    // Operand select: the top bit of an operand code picks a coefficient.
    always_comb
    begin
        opa_sel = instr.a[OPND_W-1] ? 64'(cfg_reg[instr.a[CFG_IDX_W-1:0]])
                                    : rf[instr.a[RF_IDX_W-1:0]];
        opb_sel = instr.b[OPND_W-1] ? 64'(cfg_reg[instr.b[CFG_IDX_W-1:0]])
                                    : rf[instr.b[RF_IDX_W-1:0]];
    end

    // Shared saturating adder and the other operations that need no multiplier.
    always_comb
    begin
        sum65    = {opa_reg[63], opa_reg} + {opb_reg[63], opb_reg};
        dif65    = {opa_reg[63], opa_reg} - {opb_reg[63], opb_reg};
        avg65    = sum65 + {64'd0, sum65[64]};
        clip_res = clip32(opa_reg);
        unique case (instr.op)
            OP_ADD:  alu_res = sat62(sum65);
            OP_SUB:  alu_res = sat62(dif65);
            OP_NEG:  alu_res = -opa_reg;
            OP_NPOS: alu_res = opa_reg[63] ? -opa_reg : 64'sd0;
            OP_AVG:  alu_res = avg65[64:1];
            default: alu_res = opa_reg;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.data.cmd == CMD_WRITE) ? ST_FIN : ST_READ;
                end
            end
            ST_READ:
            begin
                if (rd_cnt_reg == RD_LAST)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (is_mul)
                begin
                    state_next = ST_MULW;
                end
                else if (pc_reg == LAST_PC)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_MULW:
            begin
                if (mul_done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        req.ready     = (state_reg == ST_IDLE);
        mul_req.start = (state_reg == ST_EXEC) && is_mul;
        mul_req.sh17  = (instr.op == OP_MUL17);
        load_out      = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);
        rsp.valid     = out_valid_reg;
        rsp.data      = out_reg;
    end

    b2dlw_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .a     (opa_reg),
        .b     (opb_reg),
        .done  (mul_done),
        .res   (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NREG; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cfg_reg[cfg_index] <= cfg_value;
            end
            if (accept)
            begin
                rd_cnt_reg <= '0;
                pc_reg     <= '0;
            end
            else if (state_reg == ST_READ)
            begin
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
            end
            else if ((state_reg == ST_EXEC && !is_mul) || (state_reg == ST_MULW && mul_done))
            begin
                pc_reg <= pc_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Grid memories: one write port and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            u_mem[{req.data.row, req.data.col}] <= req.data.u_in;
            v_mem[{req.data.row, req.data.col}] <= req.data.v_in;
        end
        rd_u_reg <= u_mem[rd_addr];
        rd_v_reg <= v_mem[rd_addr];
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg   <= req.data.row;
            col_reg   <= req.data.col;
            res_u_reg <= '0;
            res_v_reg <= '0;
            sat_reg   <= 1'b0;
        end
        if (state_reg == ST_READ && rd_cnt_reg != 3'd0)
        begin
            rf[RF_IDX_W'(rd_cnt_reg - 3'd1)] <= {{32{rd_u_reg[31]}}, rd_u_reg};
            rf[RF_IDX_W'(rd_cnt_reg + 3'd4)] <= {{32{rd_v_reg[31]}}, rd_v_reg};
        end
        if (state_reg == ST_FETCH)
        begin
            opa_reg <= opa_sel;
            opb_reg <= opb_sel;
        end
        if (state_reg == ST_EXEC && !is_mul)
        begin
            if (instr.op == OP_CLIPU)
            begin
                res_u_reg <= clip_res[31:0];
                sat_reg   <= sat_reg | clip_res[32];
            end
            else if (instr.op == OP_CLIPV)
            begin
                res_v_reg <= clip_res[31:0];
                sat_reg   <= sat_reg | clip_res[32];
            end
            else
            begin
                rf[instr.dst] <= alu_res;
            end
        end
        if (state_reg == ST_MULW && mul_done)
        begin
            rf[instr.dst] <= mul_res;
        end
        if (load_out)
        begin
            out_reg.u_out     <= res_u_reg;
            out_reg.v_out     <= res_v_reg;
            out_reg.saturated <= sat_reg;
        end
    end

    // A write item goes straight to result hand-off.
    a_write_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> state_reg == ST_FIN)
        else $error("write item did not go to result hand-off");

    // The multiplier only finishes while the sequencer waits for it.
    a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_MULW)
        else $error("multiplier result arrived outside the wait state");

    // The program counter never runs past the last step.
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |-> pc_reg <= LAST_PC)
        else $error("program counter beyond last step");

endmodule

// ===== design/b2dlw_mul.sv =====
// ----------------------------------------------------------------------------
// b2dlw_mul: multi-cycle Q16.16 multiplier
// Forms the exact product of two magnitudes from four 32x32 partial
// products, one per cycle, then rounds half away from zero, saturates and
// applies the sign.
// ----------------------------------------------------------------------------
module b2dlw_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  b2dlw_pkg::mul_req_t       req,
    input  logic signed [63:0]        a,
    input  logic signed [63:0]        b,
    output logic                      done,
    output logic signed [63:0]        res
);
    import b2dlw_pkg::*;

    localparam logic [2:0] CNT_FIRST_PP = 3'd1;
    localparam logic [2:0] CNT_LAST_PP  = 3'd4;
    localparam logic [2:0] CNT_LAST_ACC = 3'd5;
    localparam logic [2:0] CNT_ROUND    = 3'd6;

    logic               busy_reg;
    logic [2:0]         cnt_reg;
    logic               done_reg;
    logic               neg_reg;
    logic               sh17_reg;
    logic [63:0]        ma_reg;
    logic [63:0]        mb_reg;
    logic [63:0]        pp_reg;
    logic [1:0]         psh_reg;
    logic [127:0]       acc_reg;
    logic signed [63:0] res_reg;

    logic [1:0]   k;
    logic [31:0]  ah;
    logic [31:0]  bh;
    logic [127:0] pp_ext;
    logic [127:0] rnd;
    logic [127:0] q128;
    logic [63:0]  qm;

    always_comb
    begin
        k  = 2'(cnt_reg - CNT_FIRST_PP);
        ah = k[1] ? ma_reg[63:32] : ma_reg[31:0];
        bh = k[0] ? mb_reg[63:32] : mb_reg[31:0];
        unique case (psh_reg)
            2'd0:    pp_ext = {64'd0, pp_reg};
            2'd1:    pp_ext = {32'd0, pp_reg, 32'd0};
            default: pp_ext = {pp_reg, 64'd0};
        endcase
        rnd  = acc_reg + (sh17_reg ? 128'h1_0000 : 128'h8000);
        q128 = sh17_reg ? (rnd >> 17) : (rnd >> 16);
        qm   = (|q128[127:62]) ? 64'(LIM64) : q128[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_FIRST_PP;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_ROUND)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg  <= a[63] ^ b[63];
            sh17_reg <= req.sh17;
            ma_reg   <= a[63] ? 64'(-a) : 64'(a);
            mb_reg   <= b[63] ? 64'(-b) : 64'(b);
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg >= CNT_FIRST_PP && cnt_reg <= CNT_LAST_PP)
            begin
                pp_reg  <= ah * bh;
                psh_reg <= {1'b0, k[1]} + {1'b0, k[0]};
            end
            if (cnt_reg > CNT_FIRST_PP && cnt_reg <= CNT_LAST_ACC)
            begin
                acc_reg <= acc_reg + pp_ext;
            end
            if (cnt_reg == CNT_ROUND)
            begin
                res_reg <= neg_reg ? -$signed(qm) : $signed(qm);
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
